FILE: rtl/htc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_pkg
// Shared types, constants and width helpers for the transform chain block.
// ----------------------------------------------------------------------------
package htc_pkg;

  // fixed element width of the data fields
  localparam int DATA_WIDTH = 32;
  localparam int NUM_COLS   = 4;
  localparam int NUM_ELEMS  = 16;
  // truncated products are clamped to +-2^TERM_LIMIT_LOG2
  localparam int TERM_LIMIT_LOG2 = 60;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // one input row of a transform
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] elem_c0;
    logic signed [DATA_WIDTH-1:0] elem_c1;
    logic signed [DATA_WIDTH-1:0] elem_c2;
    logic signed [DATA_WIDTH-1:0] elem_c3;
    logic                         final_transform;
  } in_item_t;

  // one row of the composed result
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_c0;
    logic signed [DATA_WIDTH-1:0] out_c1;
    logic signed [DATA_WIDTH-1:0] out_c2;
    logic signed [DATA_WIDTH-1:0] out_c3;
    logic [1:0]                   row_number;
    logic                         last_row;
    logic                         saturated;
  } out_item_t;

  // sideband that travels with a row through the pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] row_idx;
    logic       have_acc;
    logic       final_tr;
  } stage_ctl_t;

  typedef enum logic {
    EMIT_IDLE,
    EMIT_BUSY
  } emit_state_e;

  // width of one truncated and clamped product term
  function automatic int term_width(int frac_bits);
    int shw;
    shw = 2 * DATA_WIDTH - frac_bits;
    return (shw < TERM_LIMIT_LOG2 + 2) ? shw : TERM_LIMIT_LOG2 + 2;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/htc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_front
// Input register stage; tracks row position and chain mode per transaction.
// ----------------------------------------------------------------------------
module htc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire htc_pkg::in_item_t  in_item_i,
  output logic                    in_stall_o,
  input  wire logic               advance_i,
  output htc_pkg::stage_ctl_t     s1_ctl_o,
  output htc_pkg::data_t          s1_row_o [htc_pkg::NUM_COLS]
);

  htc_pkg::stage_ctl_t s1_ctl_q;
  htc_pkg::data_t      s1_row_q [htc_pkg::NUM_COLS];
  logic [1:0]          row_cnt_q;
  logic                have_acc_q;
  logic                accept;

  // stage frees up when its row moves on
  assign in_stall_o = s1_ctl_q.valid & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // control: row counter, chain mode, stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q   <= '0;
      row_cnt_q  <= '0;
      have_acc_q <= 1'b0;
    end else if (accept) begin
      s1_ctl_q.valid    <= 1'b1;
      s1_ctl_q.row_idx  <= row_cnt_q;
      s1_ctl_q.have_acc <= have_acc_q;
      s1_ctl_q.final_tr <= in_item_i.final_transform;
      row_cnt_q         <= row_cnt_q + 2'd1;
      if (row_cnt_q == 2'd3) begin
        have_acc_q <= ~in_item_i.final_transform;
      end
    end else if (advance_i) begin
      s1_ctl_q.valid <= 1'b0;
    end
  end

  // row payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q[0] <= in_item_i.elem_c0;
      s1_row_q[1] <= in_item_i.elem_c1;
      s1_row_q[2] <= in_item_i.elem_c2;
      s1_row_q[3] <= in_item_i.elem_c3;
    end
  end

  assign s1_ctl_o = s1_ctl_q;
  assign s1_row_o = s1_row_q;

endmodule
`default_nettype wire

FILE: rtl/htc_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_mult
// Product stage: sixteen products of accumulator column k and the input row,
// truncated by the fraction bits and clamped, then registered.
// ----------------------------------------------------------------------------
module htc_mult #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire htc_pkg::stage_ctl_t s1_ctl_i,
  input  wire htc_pkg::data_t      s1_row_i [htc_pkg::NUM_COLS],
  input  wire htc_pkg::data_t      acc_i [htc_pkg::NUM_ELEMS],
  input  wire logic                take_i,
  output logic                     advance_o,
  output htc_pkg::stage_ctl_t      s2_ctl_o,
  output htc_pkg::data_t           s2_row_o [htc_pkg::NUM_COLS],
  output logic signed [htc_pkg::term_width(FRAC_BITS)-1:0]
                                   s2_terms_o [htc_pkg::NUM_ELEMS]
);

  localparam int PW  = 2 * htc_pkg::DATA_WIDTH;
  localparam int TW  = htc_pkg::term_width(FRAC_BITS);
  localparam int CW  = (PW > htc_pkg::TERM_LIMIT_LOG2 + 2) ? PW : htc_pkg::TERM_LIMIT_LOG2 + 2;
  localparam logic signed [CW-1:0] TermMax =
    {{(CW - htc_pkg::TERM_LIMIT_LOG2 - 1){1'b0}}, 1'b1, {htc_pkg::TERM_LIMIT_LOG2{1'b0}}};
  localparam logic signed [CW-1:0] TermMin = -TermMax;

  htc_pkg::stage_ctl_t  s2_ctl_q;
  htc_pkg::data_t       s2_row_q [htc_pkg::NUM_COLS];
  logic signed [TW-1:0] s2_terms_q [htc_pkg::NUM_ELEMS];
  logic signed [TW-1:0] term_d [htc_pkg::NUM_ELEMS];
  logic                 s2_holds_last;

  // the accumulator changes when a fourth row retires, so nothing passes
  // behind a fourth row until it has left this stage
  assign s2_holds_last = s2_ctl_q.valid & (s2_ctl_q.row_idx == 2'd3);
  assign advance_o     = s1_ctl_i.valid & (~s2_ctl_q.valid | take_i) & ~s2_holds_last;

  // one multiplier per matrix element
  for (genvar e = 0; e < htc_pkg::NUM_ELEMS; e++) begin : g_elem
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic signed [CW-1:0] wide;
    logic signed [CW-1:0] clamped;
    always_comb begin
      prod    = acc_i[{2'(e / htc_pkg::NUM_COLS), s1_ctl_i.row_idx}]
                * s1_row_i[e % htc_pkg::NUM_COLS];
      shifted = prod >>> FRAC_BITS;
      wide    = CW'(shifted);
      if (wide > TermMax) begin
        clamped = TermMax;
      end else if (wide < TermMin) begin
        clamped = TermMin;
      end else begin
        clamped = wide;
      end
      term_d[e] = clamped[TW-1:0];
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (advance_o) begin
      s2_ctl_q <= s1_ctl_i;
    end else if (take_i) begin
      s2_ctl_q.valid <= 1'b0;
    end
  end

  // products and raw row
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      s2_terms_q <= term_d;
      s2_row_q   <= s1_row_i;
    end
  end

  assign s2_ctl_o   = s2_ctl_q;
  assign s2_row_o   = s2_row_q;
  assign s2_terms_o = s2_terms_q;

endmodule
`default_nettype wire

FILE: rtl/htc_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_accum
// Partial sums, saturation into the accumulator matrix and the sticky
// saturation flag; copies the first transform of a chain.
// ----------------------------------------------------------------------------
module htc_accum #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire htc_pkg::stage_ctl_t s2_ctl_i,
  input  wire htc_pkg::data_t      s2_row_i [htc_pkg::NUM_COLS],
  input  wire logic signed [htc_pkg::term_width(FRAC_BITS)-1:0]
                                   s2_terms_i [htc_pkg::NUM_ELEMS],
  input  wire logic                emit_busy_i,
  output logic                     take_o,
  output htc_pkg::data_t           acc_o [htc_pkg::NUM_ELEMS],
  output logic                     burst_start_o,
  output logic                     burst_sat_o
);

  localparam int TW = htc_pkg::term_width(FRAC_BITS);
  localparam int SW = TW + 2;
  localparam int EW = ((SW > htc_pkg::DATA_WIDTH) ? SW : htc_pkg::DATA_WIDTH) + 1;
  localparam logic signed [EW-1:0] DataMax = EW'({1'b0, {(htc_pkg::DATA_WIDTH-1){1'b1}}});
  localparam logic signed [EW-1:0] DataMin = -DataMax - EW'(1);

  logic signed [SW-1:0]   psum_q [htc_pkg::NUM_ELEMS];
  logic signed [SW-1:0]   sum_d  [htc_pkg::NUM_ELEMS];
  htc_pkg::data_t         sat_val [htc_pkg::NUM_ELEMS];
  logic [htc_pkg::NUM_ELEMS-1:0] sat_hit;
  htc_pkg::data_t         acc_q [htc_pkg::NUM_ELEMS];
  logic                   sat_seen_q;
  logic                   is_last;
  logic                   sat_now;

  assign take_o        = s2_ctl_i.valid & ~emit_busy_i;
  assign is_last       = s2_ctl_i.row_idx == 2'd3;
  assign sat_now       = s2_ctl_i.have_acc & is_last & (|sat_hit);
  assign burst_start_o = take_o & is_last & s2_ctl_i.final_tr;
  assign burst_sat_o   = sat_seen_q | sat_now;

  // add the new term and saturate the finished sum
  for (genvar e = 0; e < htc_pkg::NUM_ELEMS; e++) begin : g_elem
    logic signed [EW-1:0] wide;
    always_comb begin
      sum_d[e] = psum_q[e] + SW'(s2_terms_i[e]);
      wide     = EW'(sum_d[e]);
      if (wide > DataMax) begin
        sat_val[e] = htc_pkg::DATA_WIDTH'(DataMax);
        sat_hit[e] = 1'b1;
      end else if (wide < DataMin) begin
        sat_val[e] = htc_pkg::DATA_WIDTH'(DataMin);
        sat_hit[e] = 1'b1;
      end else begin
        sat_val[e] = htc_pkg::DATA_WIDTH'(wide);
        sat_hit[e] = 1'b0;
      end
    end
  end

  // partial sums and sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < htc_pkg::NUM_ELEMS; e++) begin
        psum_q[e] <= '0;
      end
      sat_seen_q <= 1'b0;
    end else if (take_o) begin
      if (s2_ctl_i.have_acc) begin
        for (int e = 0; e < htc_pkg::NUM_ELEMS; e++) begin
          psum_q[e] <= is_last ? '0 : sum_d[e];
        end
      end
      if (is_last && s2_ctl_i.final_tr) begin
        sat_seen_q <= 1'b0;
      end else if (sat_now) begin
        sat_seen_q <= 1'b1;
      end
    end
  end

  // accumulator matrix: copy of the first transform or the saturated product
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      for (int e = 0; e < htc_pkg::NUM_ELEMS; e++) begin
        if (s2_ctl_i.have_acc) begin
          if (is_last) begin
            acc_q[e] <= sat_val[e];
          end
        end else if (2'(e / htc_pkg::NUM_COLS) == s2_ctl_i.row_idx) begin
          acc_q[e] <= s2_row_i[e % htc_pkg::NUM_COLS];
        end
      end
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

FILE: rtl/htc_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_emit
// Result burst sequencer: moves the four accumulator rows into the output
// register one per transaction.
// ----------------------------------------------------------------------------
module htc_emit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               burst_start_i,
  input  wire logic               burst_sat_i,
  input  wire htc_pkg::data_t     acc_i [htc_pkg::NUM_ELEMS],
  output logic                    emit_busy_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output htc_pkg::out_item_t      out_item_o
);

  htc_pkg::emit_state_e state_q, state_d;
  logic [1:0]           row_q, row_d;
  logic                 sat_q;
  logic                 out_valid_q, out_valid_d;
  htc_pkg::out_item_t   out_q;
  logic                 load;

  // next state and output register load
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    load        = 1'b0;
    unique case (state_q)
      htc_pkg::EMIT_IDLE: begin
        if (burst_start_i) begin
          state_d = htc_pkg::EMIT_BUSY;
          row_d   = 2'd0;
        end
      end
      htc_pkg::EMIT_BUSY: begin
        load = ~out_valid_q | ~out_stall_i;
        if (load) begin
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) begin
            state_d = htc_pkg::EMIT_IDLE;
          end
        end
      end
      default: state_d = htc_pkg::EMIT_IDLE;
    endcase
    out_valid_d = load | (out_valid_q & out_stall_i);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htc_pkg::EMIT_IDLE;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // burst flag capture and output payload
  always_ff @(posedge clk_i) begin
    if (burst_start_i) begin
      sat_q <= burst_sat_i;
    end
    if (load) begin
      out_q.out_c0     <= acc_i[{row_q, 2'd0}];
      out_q.out_c1     <= acc_i[{row_q, 2'd1}];
      out_q.out_c2     <= acc_i[{row_q, 2'd2}];
      out_q.out_c3     <= acc_i[{row_q, 2'd3}];
      out_q.row_number <= row_q;
      out_q.last_row   <= row_q == 2'd3;
      out_q.saturated  <= sat_q;
    end
  end

  assign emit_busy_o = state_q == htc_pkg::EMIT_BUSY;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/homogeneous_transform_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_transform_chain
// Composes a chain of 4x4 transforms in signed fixed point, one row per
// transaction, and returns the four rows of the product after the last one.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------
//  input   | in_valid_i / in_stall_o | in_item_i  (one transform row)
//  output  | out_valid_o / out_stall_i | out_item_o (one result row)
//
// A row is taken every cycle while no result burst holds the accumulate stage,
// except for a bubble after each fourth row while the accumulator is rewritten.
// Pipeline: input register, product register (16 multipliers), accumulate.
// A final transform gives a burst of four result rows, one per cycle while out_stall_i is low; the
// accumulate stage holds during the burst and the input side fills behind it.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module homogeneous_transform_chain #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire htc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output htc_pkg::out_item_t      out_item_o
);

  localparam int TW = htc_pkg::term_width(FRAC_BITS);

  htc_pkg::stage_ctl_t  s1_ctl, s2_ctl;
  htc_pkg::data_t       s1_row [htc_pkg::NUM_COLS];
  htc_pkg::data_t       s2_row [htc_pkg::NUM_COLS];
  logic signed [TW-1:0] s2_terms [htc_pkg::NUM_ELEMS];
  htc_pkg::data_t       acc [htc_pkg::NUM_ELEMS];
  logic                 advance;
  logic                 take;
  logic                 emit_busy;
  logic                 burst_start;
  logic                 burst_sat;

  // input register stage
  htc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .s1_ctl_o   (s1_ctl),
    .s1_row_o   (s1_row)
  );

  // product stage
  htc_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_ctl_i   (s1_ctl),
    .s1_row_i   (s1_row),
    .acc_i      (acc),
    .take_i     (take),
    .advance_o  (advance),
    .s2_ctl_o   (s2_ctl),
    .s2_row_o   (s2_row),
    .s2_terms_o (s2_terms)
  );

  // accumulate stage
  htc_accum #(.FRAC_BITS(FRAC_BITS)) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s2_ctl_i      (s2_ctl),
    .s2_row_i      (s2_row),
    .s2_terms_i    (s2_terms),
    .emit_busy_i   (emit_busy),
    .take_o        (take),
    .acc_o         (acc),
    .burst_start_o (burst_start),
    .burst_sat_o   (burst_sat)
  );

  // result burst
  htc_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_start_i (burst_start),
    .burst_sat_i   (burst_sat),
    .acc_i         (acc),
    .emit_busy_o   (emit_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  // a burst never starts on top of another one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_start |-> !emit_busy)
    else $error("burst started while emitter busy");

  // a started burst occupies the emitter in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_start |=> emit_busy)
    else $error("burst start lost");

  // no row reads the accumulator while a fourth row is still to retire
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(s2_ctl.valid && s2_ctl.row_idx == 2'd3))
    else $error("row passed an unretired fourth row");

  // rows of a burst follow one another without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_row |=> out_valid_o)
    else $error("gap inside result burst");

endmodule
`default_nettype wire
